### design/assert_macros.svh
// Assertion helpers used by the RTL control file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define GQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication checked outside reset.
`define GQR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

### design/gqr_pkg.sv
package gqr_pkg;

  localparam int MAX_DIM    = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 4;
  localparam int DATA_W     = 32;
  localparam int DIM_W      = 5;
  localparam int CS_W       = FRAC_BITS + 2;
  localparam int NUM_W      = FRAC_BITS + DATA_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = 6;
  localparam int ADDR_W     = 2 * IDX_W;

  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);

  // register indexes on the config port
  localparam logic REG_ACTIVE_FEATURES = 1'b0;
  localparam logic REG_ADD_INTERCEPT   = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ_R = 2'd2,
    OP_READ_P = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MM_SQ   = 2'd0,
    MM_ROT1 = 2'd1,
    MM_ROT2 = 2'd2
  } mul_mode_e;

  typedef enum logic [1:0] {
    RS_RESP = 2'd0,
    RS_MEM  = 2'd1,
    RS_PROJ = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic             load_row;
    logic             start_upd;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] ca;
    logic             ld_mem;
    logic             ld_proj;
    logic             mul_first;
    logic             mul_second;
    logic             acc_add;
    mul_mode_e        mode;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             sqrt_fin;
    logic             div_init;
    logic             div_sn;
    logic             div_step;
    logic             div_fin;
    logic             wr_r;
    logic             wr_work;
    logic             wr_proj;
    logic             wr_resp;
    logic             res_cap;
    res_sel_e         res_sel;
    logic             push;
  } gqr_cmd_t;

endpackage

### design/givens_qr_row_update.sv
// Load item: writes the row buffer. Read items: a projected response entry is captured on
// accept, a factor entry after a memory read state; both wait in the push state. Update:
// columns whose lower entry is zero are skipped, the rest use the 32-step square root,
// two 48-step divisions and one shared multiplier. One item at a time; the next is taken
// once a result is queued (a load queues none). Reset clears the factor (valid bits),
// projected response, row buffer and control; active_features and add_intercept reset to 1.
module givens_qr_row_update import gqr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     kind_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     saturated_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [DIM_W-1:0] af_q;
  logic             ai_q;
  logic [DIM_W-1:0] feats, dim;
  logic [DIM_W:0]   dim_sum;
  logic             wr_en;
  logic             lower_zero;
  gqr_cmd_t         cmd;

  // config registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= DIM_W'(1);
      ai_q <= 1'b1;
    end else if (wr_en) begin
      if (paddr[2] == REG_ACTIVE_FEATURES) begin
        af_q <= pwdata[DIM_W-1:0];
      end else begin
        ai_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ADD_INTERCEPT) ? {31'b0, ai_q} : {27'b0, af_q};

  // working dimension
  assign feats   = (af_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : af_q;
  assign dim_sum = {1'b0, feats} + {{DIM_W{1'b0}}, ai_q};
  assign dim     = (dim_sum > (DIM_W+1)'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_sum[DIM_W-1:0];

  gqr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .op_i         (op_i),
    .col_index_i  (col_index_i),
    .row_index_i  (row_index_i),
    .dim_i        (dim),
    .lower_zero_i (lower_zero),
    .out_stall_i  (out_stall_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  gqr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .feats_i      (feats),
    .dim_i        (dim),
    .intercept_i  (ai_q),
    .col_index_i  (col_index_i),
    .value_i      (value_i),
    .lower_zero_o (lower_zero),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .saturated_o  (saturated_o)
  );

endmodule

### design/gqr_datapath.sv
module gqr_datapath import gqr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gqr_cmd_t                 cmd_i,
  input  logic [DIM_W-1:0]         feats_i,
  input  logic [DIM_W-1:0]         dim_i,
  input  logic                     intercept_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     lower_zero_o,
  output logic                     kind_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     saturated_o
);

  // factor store with per-entry valid bits (unwritten reads as zero)
  logic [DATA_W-1:0]  mem [MAX_DIM*MAX_DIM];
  logic [MAX_DIM*MAX_DIM-1:0] vld_q;
  logic [DATA_W-1:0]  rd_q;
  logic               rd_vld_q;
  logic [ADDR_W-1:0]  addr;
  logic [DATA_W-1:0]  rd_val;

  logic signed [DATA_W-1:0] rowbuf_q [MAX_DIM];
  logic signed [DATA_W-1:0] proj_q   [MAX_DIM];
  logic signed [DATA_W-1:0] work_q   [MAX_DIM];
  logic signed [DATA_W-1:0] resp_q;
  logic                     sat_q;

  logic signed [DATA_W-1:0] top_q, bot_q;
  logic signed [CS_W-1:0]   cs_q, sn_q;
  logic signed [DATA_W:0]   mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [2*DATA_W:0] prod_full;
  logic signed [63:0]       prod_q, acc_q;

  logic signed [63:0]       rnd_full;
  logic signed [DATA_W-1:0] rnd;
  logic                     rnd_sat;

  logic [63:0]       sx_q, sres_q, sbit_q, strial;
  logic [DATA_W-2:0] radius_q;

  logic [NUM_W-1:0]  num_q, qs;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W:0]   remt;
  logic              neg_q;
  logic [DATA_W:0]   mag_ext;
  logic [DATA_W-1:0] mag;
  logic signed [DATA_W-1:0] div_src;

  logic                     out_kind_q, out_sat_q, res_kind_q, res_sat_q;
  logic signed [DATA_W-1:0] out_data_q, res_q;

  assign addr   = {cmd_i.ra, cmd_i.ca};
  assign rd_val = rd_vld_q ? rd_q : '0;

  // memory array
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_r) begin
      mem[addr] <= rnd;
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_r) begin
        vld_q[addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_b = cmd_i.mul_first ? top_q : bot_q;
    case (cmd_i.mode)
      MM_SQ:   mul_a = cmd_i.mul_first ? (DATA_W+1)'(top_q) : (DATA_W+1)'(bot_q);
      MM_ROT1: mul_a = cmd_i.mul_first ? (DATA_W+1)'(cs_q) : (DATA_W+1)'(sn_q);
      MM_ROT2: mul_a = cmd_i.mul_first ? -(DATA_W+1)'(sn_q) : (DATA_W+1)'(cs_q);
      default: mul_a = '0;
    endcase
  end
  assign prod_full = mul_a * mul_b;

  // round half up, then saturate
  always_comb begin
    rnd_full = (acc_q + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    rnd_sat  = 1'b0;
    rnd      = rnd_full[DATA_W-1:0];
    if (rnd_full > 64'sd2147483647) begin
      rnd     = {1'b0, {(DATA_W-1){1'b1}}};
      rnd_sat = 1'b1;
    end else if (rnd_full < -64'sd2147483648) begin
      rnd     = {1'b1, {(DATA_W-1){1'b0}}};
      rnd_sat = 1'b1;
    end
  end

  // sqrt and divide steps
  assign strial  = sres_q + sbit_q;
  assign remt    = {rem_q, num_q[NUM_W-1]};
  assign div_src = cmd_i.div_sn ? bot_q : top_q;
  assign mag_ext = div_src[DATA_W-1] ? -(DATA_W+1)'(div_src) : (DATA_W+1)'(div_src);
  assign mag     = mag_ext[DATA_W-1:0];
  assign qs      = neg_q ? -num_q : num_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_first || cmd_i.mul_second) begin
      prod_q <= prod_full[63:0];
    end
    if (cmd_i.mul_second) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.ld_mem) begin
      top_q <= rd_val;
      bot_q <= work_q[cmd_i.ca];
    end else if (cmd_i.ld_proj) begin
      top_q <= proj_q[cmd_i.ra];
      bot_q <= resp_q;
    end
    if (cmd_i.sqrt_init) begin
      sx_q   <= acc_q;
      sres_q <= '0;
      sbit_q <= 64'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (sx_q >= strial) begin
        sx_q   <= sx_q - strial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.sqrt_fin) begin
      radius_q <= (sres_q > 64'd2147483647) ? '1 : sres_q[DATA_W-2:0];
    end
    if (cmd_i.div_init) begin
      num_q <= {mag, FRAC_BITS'(0)};
      rem_q <= '0;
      neg_q <= div_src[DATA_W-1];
    end else if (cmd_i.div_step) begin
      if (remt >= {2'b00, radius_q}) begin
        rem_q <= DATA_W'(remt - {2'b00, radius_q});
        num_q <= {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= remt[DATA_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      if (cmd_i.div_sn) begin
        sn_q <= qs[CS_W-1:0];
      end else begin
        cs_q <= qs[CS_W-1:0];
      end
    end
    if (cmd_i.start_upd) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        if (intercept_i && dim_i != '0 && DIM_W'(i) == dim_i - DIM_W'(1)) begin
          work_q[i] <= ONE_FX;
        end else begin
          work_q[i] <= rowbuf_q[i];
        end
      end
      resp_q <= value_i;
    end else begin
      if (cmd_i.wr_work) begin
        work_q[cmd_i.ca] <= rnd;
      end
      if (cmd_i.wr_resp) begin
        resp_q <= rnd;
      end
    end
    if (cmd_i.res_cap) begin
      case (cmd_i.res_sel)
        RS_MEM:  res_q <= rd_val;
        RS_PROJ: res_q <= proj_q[cmd_i.ra];
        default: res_q <= resp_q;
      endcase
      res_kind_q <= (cmd_i.res_sel != RS_RESP);
      res_sat_q  <= (cmd_i.res_sel == RS_RESP) && sat_q;
    end
    if (cmd_i.push) begin
      out_data_q <= res_q;
      out_kind_q <= res_kind_q;
      out_sat_q  <= res_sat_q;
    end
  end

  // row buffer, projected response and saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        rowbuf_q[i] <= '0;
        proj_q[i]   <= '0;
      end
      sat_q <= 1'b0;
    end else begin
      if (cmd_i.start_upd) begin
        for (int i = 0; i < MAX_DIM; i++) begin
          rowbuf_q[i] <= '0;
        end
        sat_q <= 1'b0;
      end else begin
        if (cmd_i.load_row && DIM_W'(col_index_i) < feats_i) begin
          rowbuf_q[col_index_i] <= value_i;
        end
        if (cmd_i.wr_proj) begin
          proj_q[cmd_i.ra] <= rnd;
        end
        if ((cmd_i.wr_r || cmd_i.wr_work || cmd_i.wr_proj || cmd_i.wr_resp) && rnd_sat) begin
          sat_q <= 1'b1;
        end
        if (cmd_i.sqrt_fin && sres_q > 64'd2147483647) begin
          sat_q <= 1'b1;
        end
      end
    end
  end

  assign lower_zero_o = (bot_q == '0);
  assign kind_o       = out_kind_q;
  assign data_o       = out_data_q;
  assign saturated_o  = out_sat_q;

endmodule

### design/gqr_ctrl.sv
`include "assert_macros.svh"

module gqr_ctrl import gqr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       op_i,
  input  logic [IDX_W-1:0] col_index_i,
  input  logic [IDX_W-1:0] row_index_i,
  input  logic [DIM_W-1:0] dim_i,
  input  logic             lower_zero_i,
  input  logic             out_stall_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output gqr_cmd_t         cmd_o
);

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001, S_RD   = 24'h000002, S_FIN  = 24'h000004,
    S_PUSH = 24'h000008, S_JRD  = 24'h000010, S_JLD  = 24'h000020,
    S_JCHK = 24'h000040, S_M1   = 24'h000080, S_M2   = 24'h000100,
    S_M3   = 24'h000200, S_SQI  = 24'h000400, S_SQ   = 24'h000800,
    S_SQF  = 24'h001000, S_DVI  = 24'h002000, S_DV   = 24'h004000,
    S_DVF  = 24'h008000, S_CRD  = 24'h010000, S_CLD  = 24'h020000,
    S_WR   = 24'h040000, S_WW   = 24'h080000, S_PLD  = 24'h100000,
    S_WP   = 24'h200000, S_WS   = 24'h400000, S_JNX  = 24'h800000
  } state_e;

  typedef enum logic [2:0] {
    PH_SQ = 3'd0, PH_R = 3'd1, PH_W = 3'd2, PH_P = 3'd3, PH_S = 3'd4
  } phase_e;

  state_e           state_q, state_d;
  phase_e           ph_q, ph_d;
  logic [IDX_W-1:0] j_q, j_d, c_q, c_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             dsn_q, dsn_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic [DIM_W-1:0] last;
  gqr_cmd_t         cmd;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = dim_i - DIM_W'(1);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    j_d     = j_q;
    c_d     = c_q;
    cnt_d   = cnt_q;
    dsn_d   = dsn_q;
    cmd     = '0;
    cmd.ra  = j_q;
    cmd.ca  = c_q;
    cmd.div_sn = dsn_q;
    case (ph_q)
      PH_SQ:       cmd.mode = MM_SQ;
      PH_R, PH_P:  cmd.mode = MM_ROT1;
      default:     cmd.mode = MM_ROT2;
    endcase
    case (state_q)
      S_IDLE: begin
        cmd.ra = row_index_i;
        cmd.ca = col_index_i;
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_LOAD: cmd.load_row = 1'b1;
            OP_UPDATE: begin
              cmd.start_upd = 1'b1;
              j_d = '0;
              state_d = (dim_i == '0) ? S_FIN : S_JRD;
            end
            OP_READ_R: state_d = S_RD;
            default: begin
              cmd.res_cap = 1'b1;
              cmd.res_sel = RS_PROJ;
              state_d = S_PUSH;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.res_cap = 1'b1;
        cmd.res_sel = RS_MEM;
        state_d = S_PUSH;
      end
      S_FIN: begin
        cmd.res_cap = 1'b1;
        cmd.res_sel = RS_RESP;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_JRD: begin
        cmd.ca = j_q;
        state_d = S_JLD;
      end
      S_JLD: begin
        cmd.ca = j_q;
        cmd.ld_mem = 1'b1;
        state_d = S_JCHK;
      end
      S_JCHK: begin
        if (lower_zero_i) begin
          state_d = S_JNX;
        end else begin
          ph_d = PH_SQ;
          state_d = S_M1;
        end
      end
      S_M1: begin
        cmd.mul_first = 1'b1;
        state_d = S_M2;
      end
      S_M2: begin
        cmd.mul_second = 1'b1;
        state_d = S_M3;
      end
      S_M3: begin
        cmd.acc_add = 1'b1;
        case (ph_q)
          PH_SQ:   state_d = S_SQI;
          PH_R:    state_d = S_WR;
          PH_W:    state_d = S_WW;
          PH_P:    state_d = S_WP;
          default: state_d = S_WS;
        endcase
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_d = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd.sqrt_step = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = S_SQF;
        end
      end
      S_SQF: begin
        cmd.sqrt_fin = 1'b1;
        dsn_d = 1'b0;
        state_d = S_DVI;
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        cnt_d = '0;
        state_d = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DVF;
        end
      end
      S_DVF: begin
        cmd.div_fin = 1'b1;
        if (!dsn_q) begin
          dsn_d = 1'b1;
          state_d = S_DVI;
        end else begin
          dsn_d = 1'b0;
          c_d = j_q;
          state_d = S_CRD;
        end
      end
      S_CRD: state_d = S_CLD;
      S_CLD: begin
        cmd.ld_mem = 1'b1;
        ph_d = PH_R;
        state_d = S_M1;
      end
      S_WR: begin
        cmd.wr_r = 1'b1;
        ph_d = PH_W;
        state_d = S_M1;
      end
      S_WW: begin
        cmd.wr_work = 1'b1;
        if (DIM_W'(c_q) == last) begin
          state_d = S_PLD;
        end else begin
          c_d = c_q + IDX_W'(1);
          state_d = S_CRD;
        end
      end
      S_PLD: begin
        cmd.ld_proj = 1'b1;
        ph_d = PH_P;
        state_d = S_M1;
      end
      S_WP: begin
        cmd.wr_proj = 1'b1;
        ph_d = PH_S;
        state_d = S_M1;
      end
      S_WS: begin
        cmd.wr_resp = 1'b1;
        state_d = S_JNX;
      end
      S_JNX: begin
        if (DIM_W'(j_q) == last) begin
          state_d = S_FIN;
        end else begin
          j_d = j_q + IDX_W'(1);
          state_d = S_JRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_SQ;
      j_q         <= '0;
      c_q         <= '0;
      cnt_q       <= '0;
      dsn_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      j_q         <= j_d;
      c_q         <= c_d;
      cnt_q       <= cnt_d;
      dsn_q       <= dsn_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `GQR_ASSERT_IMP(a_push_free, cmd.push, !out_valid_q || !out_stall_i, "push into full output")
  `GQR_ASSERT_IMP(a_col_range, state_q == S_CRD, c_q >= j_q && DIM_W'(c_q) < dim_i, "column out of range")
  `GQR_ASSERT(a_div_count, (state_q == S_DV) |-> (cnt_q < CNT_W'(DIV_STEPS)), "divider overrun")

endmodule
